FILE: rtl/core/tso_pkg.sv
package tso_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 3'd3;

  // Result stream width (hit flag padded to one byte)
  localparam int OUT_DATA_W = 8;

  // Pipeline depth from input register to result register
  localparam int NUM_STAGES = 7;

endpackage

FILE: rtl/core/triangle_sphere_overlap_test.sv
// Throughput: one triangle per cycle while out_tready is high; every stage has
// its own valid bit and advances when empty or when the stage after it advances.
// Reset: rst_n is synchronous, active low; it clears the pipeline valid bits,
// the sphere center and the radius. Datapath registers are not reset.
module triangle_sphere_overlap_test
  import tso_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel: tdata = v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
  // v2_x, v2_y, v2_z (lowest bits first), zero padded to whole bytes
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // result channel: tdata = hit (bit 0), rest zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_DATA_W-1:0]           out_tdata,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [COORD_WIDTH-1:0]          cfg_data
);

  localparam int W    = COORD_WIDTH;
  localparam int R    = W + 1;          // coordinate relative to the centre
  localparam int E    = W + 1;          // edge vector component
  localparam int RQ   = 2 * W;          // radius squared, signed
  localparam int V    = 2 * E + 1;      // plane normal component
  localparam int DT   = 2 * R + 2;      // vertex dot products
  localparam int EE   = 2 * E + 2;      // squared edge length
  localparam int DDW  = DT + 1;         // pq - pp
  localparam int DW   = R + V + 2;      // plane distance term
  localparam int EVW  = 2 * V + 2;      // squared normal length
  localparam int PEW  = R + EE;         // vertex times edge length
  localparam int EDW  = E + DDW;        // edge times dd
  localparam int QPW  = EDW + 1;        // projected point
  localparam int QRW  = QPW + 1;        // point to opposite vertex
  localparam int EE2W = 2 * EE;         // edge length squared again
  localparam int CW   = 6 * W + 18;     // compare width

  // operand splits for the wide products
  localparam int DL  = (DW + 1) / 2;
  localparam int DH  = DW - DL;
  localparam int QL  = (QPW + 1) / 2;
  localparam int QH  = QPW - QL;
  localparam int RH  = QRW - QL;
  localparam int EL  = (EVW + 1) / 2;
  localparam int EH  = EVW - EL;
  localparam int FL  = (EE2W + 1) / 2;
  localparam int FH  = EE2W - FL;

  localparam int S = NUM_STAGES;

  // configuration registers
  logic signed [W-1:0] cen_r [3];
  logic        [W-2:0] rad_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
      rad_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:      cen_r[0] <= cfg_data;
        REG_CENTER_Y:      cen_r[1] <= cfg_data;
        REG_CENTER_Z:      cen_r[2] <= cfg_data;
        REG_SPHERE_RADIUS: rad_r    <= cfg_data[W-2:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // stage control: a stage loads when it is empty or its successor loads
  logic [S-1:0] vld_r;
  logic [S-1:0] en;

  always_comb begin
    en[S-1] = !vld_r[S-1] || out_tready;
    for (int i = S - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[S-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < S; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: vertices relative to the centre, edge vectors, radius squared
  // Edge k runs from vertex k to vertex k+1; vertex k+2 is opposite.
  // ---------------------------------------------------------------------
  logic signed [W-1:0]  raw      [3][3];
  logic signed [R-1:0]  rel_nxt  [3][3];
  logic signed [E-1:0]  ed_nxt   [3][3];
  logic signed [RQ-1:0] rr_nxt;
  logic signed [R-1:0]  s1_rel_r [3][3];
  logic signed [E-1:0]  s1_ed_r  [3][3];
  logic signed [RQ-1:0] s1_rr_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        raw[j][i] = in_tdata[(3*j+i)*W +: W];
        rel_nxt[j][i] = R'(raw[j][i]) - R'(cen_r[i]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ed_nxt[k][i] = E'(raw[(k+1)%3][i]) - E'(raw[k][i]);
      end
    end
    rr_nxt = RQ'($signed({1'b0, rad_r})) * RQ'($signed({1'b0, rad_r}));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_rel_r <= rel_nxt;
      s1_ed_r  <= ed_nxt;
      s1_rr_r  <= rr_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: plane normal (edge2 x edge0), vertex dot products, |edge|^2
  // ---------------------------------------------------------------------
  logic signed [V-1:0]  nrm_nxt [3];
  logic signed [DT-1:0] dt_nxt  [3][3];
  logic signed [EE-1:0] ee_nxt  [3];
  logic signed [V-1:0]  s2_nrm_r [3];
  logic signed [DT-1:0] s2_dt_r  [3][3];
  logic signed [EE-1:0] s2_ee_r  [3];
  logic signed [R-1:0]  s2_rel_r [3][3];
  logic signed [E-1:0]  s2_ed_r  [3][3];
  logic signed [RQ-1:0] s2_rr_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_nxt[i] = V'(s1_ed_r[2][(i+1)%3]) * V'(s1_ed_r[0][(i+2)%3])
                 - V'(s1_ed_r[2][(i+2)%3]) * V'(s1_ed_r[0][(i+1)%3]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (j >= i) begin
          dt_nxt[i][j] = DT'(s1_rel_r[i][0]) * DT'(s1_rel_r[j][0])
                       + DT'(s1_rel_r[i][1]) * DT'(s1_rel_r[j][1])
                       + DT'(s1_rel_r[i][2]) * DT'(s1_rel_r[j][2]);
        end else begin
          dt_nxt[i][j] = dt_nxt[j][i];
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      ee_nxt[k] = EE'(s1_ed_r[k][0]) * EE'(s1_ed_r[k][0])
                + EE'(s1_ed_r[k][1]) * EE'(s1_ed_r[k][1])
                + EE'(s1_ed_r[k][2]) * EE'(s1_ed_r[k][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_nrm_r <= nrm_nxt;
      s2_dt_r  <= dt_nxt;
      s2_ee_r  <= ee_nxt;
      s2_rel_r <= s1_rel_r;
      s2_ed_r  <= s1_ed_r;
      s2_rr_r  <= s1_rr_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: plane distance and normal length, vertex region tests,
  // vertex times edge length terms for the edge projections
  // ---------------------------------------------------------------------
  logic signed [DDW-1:0]  dd_nxt  [3];
  logic signed [DW-1:0]   d_nxt;
  logic signed [EVW-1:0]  e_nxt;
  logic [2:0]             vsep_nxt;
  logic signed [PEW-1:0]  pe_nxt  [3][3];
  logic signed [PEW-1:0]  re_nxt  [3][3];
  logic signed [EE2W-1:0] ee2_nxt [3];
  logic signed [DDW-1:0]  s3_dd_r  [3];
  logic signed [DW-1:0]   s3_d_r;
  logic signed [EVW-1:0]  s3_e_r;
  logic [2:0]             s3_vsep_r;
  logic signed [PEW-1:0]  s3_pe_r  [3][3];
  logic signed [PEW-1:0]  s3_re_r  [3][3];
  logic signed [EE2W-1:0] s3_ee2_r [3];
  logic signed [E-1:0]    s3_ed_r  [3][3];
  logic signed [RQ-1:0]   s3_rr_r;

  always_comb begin
    d_nxt = DW'(s2_rel_r[0][0]) * DW'(s2_nrm_r[0])
          + DW'(s2_rel_r[0][1]) * DW'(s2_nrm_r[1])
          + DW'(s2_rel_r[0][2]) * DW'(s2_nrm_r[2]);
    e_nxt = EVW'(s2_nrm_r[0]) * EVW'(s2_nrm_r[0])
          + EVW'(s2_nrm_r[1]) * EVW'(s2_nrm_r[1])
          + EVW'(s2_nrm_r[2]) * EVW'(s2_nrm_r[2]);
    for (int k = 0; k < 3; k++) begin
      // vertex k lies beyond the sphere and both neighbours lie further out
      vsep_nxt[k] = (DT'(s2_rr_r) < s2_dt_r[k][k])
                 && (s2_dt_r[k][(k+1)%3] > s2_dt_r[k][k])
                 && (s2_dt_r[k][(k+2)%3] > s2_dt_r[k][k]);
      dd_nxt[k] = DDW'(s2_dt_r[k][(k+1)%3]) - DDW'(s2_dt_r[k][k]);
      ee2_nxt[k] = EE2W'(s2_ee_r[k]) * EE2W'(s2_ee_r[k]);
      for (int i = 0; i < 3; i++) begin
        pe_nxt[k][i] = PEW'(s2_rel_r[k][i]) * PEW'(s2_ee_r[k]);
        re_nxt[k][i] = PEW'(s2_rel_r[(k+2)%3][i]) * PEW'(s2_ee_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_dd_r   <= dd_nxt;
      s3_d_r    <= d_nxt;
      s3_e_r    <= e_nxt;
      s3_vsep_r <= vsep_nxt;
      s3_pe_r   <= pe_nxt;
      s3_re_r   <= re_nxt;
      s3_ee2_r  <= ee2_nxt;
      s3_ed_r   <= s2_ed_r;
      s3_rr_r   <= s2_rr_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: projected point qp and qr, partial products of d*d,
  // rr*e and rr*ee^2 (wide operands cut into halves)
  // ---------------------------------------------------------------------
  logic signed [QPW-1:0]        qp_nxt [3][3];
  logic signed [QRW-1:0]        qr_nxt [3][3];
  logic signed [DH-1:0]         d_hi;
  logic signed [DL:0]           d_lo;
  logic signed [EH-1:0]         e_hi;
  logic signed [EL:0]           e_lo;
  logic signed [FH-1:0]         f_hi   [3];
  logic signed [FL:0]           f_lo   [3];
  logic signed [2*DH-1:0]       dhh_nxt;
  logic signed [DH+DL:0]        dhl_nxt;
  logic signed [2*DL+1:0]       dll_nxt;
  logic signed [EH+RQ-1:0]      reh_nxt;
  logic signed [EL+RQ:0]        rel_lo_nxt;
  logic signed [FH+RQ-1:0]      rfh_nxt [3];
  logic signed [FL+RQ:0]        rfl_nxt [3];
  logic signed [QPW-1:0]        s4_qp_r  [3][3];
  logic signed [QRW-1:0]        s4_qr_r  [3][3];
  logic signed [2*DH-1:0]       s4_dhh_r;
  logic signed [DH+DL:0]        s4_dhl_r;
  logic signed [2*DL+1:0]       s4_dll_r;
  logic signed [EH+RQ-1:0]      s4_reh_r;
  logic signed [EL+RQ:0]        s4_rel_r;
  logic signed [FH+RQ-1:0]      s4_rfh_r [3];
  logic signed [FL+RQ:0]        s4_rfl_r [3];
  logic [2:0]                   s4_vsep_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        qp_nxt[k][i] = QPW'(s3_pe_r[k][i])
                     - QPW'(s3_ed_r[k][i]) * QPW'(s3_dd_r[k]);
        qr_nxt[k][i] = QRW'(s3_re_r[k][i]) - QRW'(qp_nxt[k][i]);
      end
      f_hi[k] = $signed(s3_ee2_r[k][EE2W-1:FL]);
      f_lo[k] = $signed({1'b0, s3_ee2_r[k][FL-1:0]});
      rfh_nxt[k] = (FH+RQ)'(f_hi[k]) * (FH+RQ)'(s3_rr_r);
      rfl_nxt[k] = (FL+RQ+1)'(f_lo[k]) * (FL+RQ+1)'(s3_rr_r);
    end
    d_hi = $signed(s3_d_r[DW-1:DL]);
    d_lo = $signed({1'b0, s3_d_r[DL-1:0]});
    dhh_nxt = (2*DH)'(d_hi) * (2*DH)'(d_hi);
    dhl_nxt = (DH+DL+1)'(d_hi) * (DH+DL+1)'(d_lo);
    dll_nxt = (2*DL+2)'(d_lo) * (2*DL+2)'(d_lo);
    e_hi = $signed(s3_e_r[EVW-1:EL]);
    e_lo = $signed({1'b0, s3_e_r[EL-1:0]});
    reh_nxt = (EH+RQ)'(e_hi) * (EH+RQ)'(s3_rr_r);
    rel_lo_nxt = (EL+RQ+1)'(e_lo) * (EL+RQ+1)'(s3_rr_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_qp_r   <= qp_nxt;
      s4_qr_r   <= qr_nxt;
      s4_dhh_r  <= dhh_nxt;
      s4_dhl_r  <= dhl_nxt;
      s4_dll_r  <= dll_nxt;
      s4_reh_r  <= reh_nxt;
      s4_rel_r  <= rel_lo_nxt;
      s4_rfh_r  <= rfh_nxt;
      s4_rfl_r  <= rfl_nxt;
      s4_vsep_r <= s3_vsep_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: assemble d*d, rr*e, rr*ee^2; partial products of qp.qp, qp.qr
  // ---------------------------------------------------------------------
  logic signed [QH-1:0]       qp_hi   [3][3];
  logic signed [QL:0]         qp_lo   [3][3];
  logic signed [RH-1:0]       qr_hi   [3][3];
  logic signed [CW-1:0]       dsq_nxt;
  logic signed [CW-1:0]       rre_nxt;
  logic signed [CW-1:0]       rree_nxt [3];
  logic signed [2*QH-1:0]     pph_nxt [3][3];
  logic signed [QH+QL:0]      ppm_nxt [3][3];
  logic signed [2*QL+1:0]     ppl_nxt [3][3];
  logic signed [QH+RH-1:0]    prhh_nxt [3][3];
  logic signed [QH+QL:0]      prhl_nxt [3][3];
  logic signed [QL+RH:0]      prlh_nxt [3][3];
  logic signed [2*QL+1:0]     prll_nxt [3][3];
  logic signed [CW-1:0]       s5_dsq_r;
  logic signed [CW-1:0]       s5_rre_r;
  logic signed [CW-1:0]       s5_rree_r [3];
  logic signed [2*QH-1:0]     s5_pph_r  [3][3];
  logic signed [QH+QL:0]      s5_ppm_r  [3][3];
  logic signed [2*QL+1:0]     s5_ppl_r  [3][3];
  logic signed [QH+RH-1:0]    s5_prhh_r [3][3];
  logic signed [QH+QL:0]      s5_prhl_r [3][3];
  logic signed [QL+RH:0]      s5_prlh_r [3][3];
  logic signed [2*QL+1:0]     s5_prll_r [3][3];
  logic [2:0]                 s5_vsep_r;

  always_comb begin
    dsq_nxt = (CW'(s4_dhh_r) <<< (2*DL)) + (CW'(s4_dhl_r) <<< (DL+1))
            + CW'(s4_dll_r);
    rre_nxt = (CW'(s4_reh_r) <<< EL) + CW'(s4_rel_r);
    for (int k = 0; k < 3; k++) begin
      rree_nxt[k] = (CW'(s4_rfh_r[k]) <<< FL) + CW'(s4_rfl_r[k]);
      for (int i = 0; i < 3; i++) begin
        qp_hi[k][i] = $signed(s4_qp_r[k][i][QPW-1:QL]);
        qp_lo[k][i] = $signed({1'b0, s4_qp_r[k][i][QL-1:0]});
        qr_hi[k][i] = $signed(s4_qr_r[k][i][QRW-1:QL]);
        pph_nxt[k][i] = (2*QH)'(qp_hi[k][i]) * (2*QH)'(qp_hi[k][i]);
        ppm_nxt[k][i] = (QH+QL+1)'(qp_hi[k][i]) * (QH+QL+1)'(qp_lo[k][i]);
        ppl_nxt[k][i] = (2*QL+2)'(qp_lo[k][i]) * (2*QL+2)'(qp_lo[k][i]);
        prhh_nxt[k][i] = (QH+RH)'(qp_hi[k][i]) * (QH+RH)'(qr_hi[k][i]);
        prhl_nxt[k][i] = (QH+QL+1)'(qp_hi[k][i])
                       * (QH+QL+1)'($signed({1'b0, s4_qr_r[k][i][QL-1:0]}));
        prlh_nxt[k][i] = (QL+RH+1)'(qp_lo[k][i]) * (QL+RH+1)'(qr_hi[k][i]);
        prll_nxt[k][i] = (2*QL+2)'(qp_lo[k][i])
                       * (2*QL+2)'($signed({1'b0, s4_qr_r[k][i][QL-1:0]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_dsq_r  <= dsq_nxt;
      s5_rre_r  <= rre_nxt;
      s5_rree_r <= rree_nxt;
      s5_pph_r  <= pph_nxt;
      s5_ppm_r  <= ppm_nxt;
      s5_ppl_r  <= ppl_nxt;
      s5_prhh_r <= prhh_nxt;
      s5_prhl_r <= prhl_nxt;
      s5_prlh_r <= prlh_nxt;
      s5_prll_r <= prll_nxt;
      s5_vsep_r <= s4_vsep_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: plane test; per component squares and products of the edges
  // ---------------------------------------------------------------------
  logic                 psep_nxt;
  logic signed [CW-1:0] qq_nxt [3][3];
  logic signed [CW-1:0] qx_nxt [3][3];
  logic                 s6_psep_r;
  logic signed [CW-1:0] s6_qq_r   [3][3];
  logic signed [CW-1:0] s6_qx_r   [3][3];
  logic signed [CW-1:0] s6_rree_r [3];
  logic [2:0]           s6_vsep_r;

  always_comb begin
    psep_nxt = s5_dsq_r > s5_rre_r;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        qq_nxt[k][i] = (CW'(s5_pph_r[k][i]) <<< (2*QL))
                     + (CW'(s5_ppm_r[k][i]) <<< (QL+1))
                     + CW'(s5_ppl_r[k][i]);
        qx_nxt[k][i] = (CW'(s5_prhh_r[k][i]) <<< (2*QL))
                     + ((CW'(s5_prhl_r[k][i]) + CW'(s5_prlh_r[k][i])) <<< QL)
                     + CW'(s5_prll_r[k][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_psep_r <= psep_nxt;
      s6_qq_r   <= qq_nxt;
      s6_qx_r   <= qx_nxt;
      s6_rree_r <= s5_rree_r;
      s6_vsep_r <= s5_vsep_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: edge tests and the result register
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] qpqp [3];
  logic signed [CW-1:0] qpqr [3];
  logic [2:0]           esep;
  logic                 hit_nxt;
  logic                 hit_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qpqp[k] = s6_qq_r[k][0] + s6_qq_r[k][1] + s6_qq_r[k][2];
      qpqr[k] = s6_qx_r[k][0] + s6_qx_r[k][1] + s6_qx_r[k][2];
      esep[k] = (qpqp[k] > s6_rree_r[k]) && (qpqr[k] > CW'(0));
    end
    hit_nxt = !(s6_psep_r || (|s6_vsep_r) || (|esep));
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_tdata = {{(OUT_DATA_W-1){1'b0}}, hit_r};

endmodule
